[hw/rtl/rwc_pkg.sv]
// Package for the anti-replay window check: bitmap geometry, FSM states and
// the request structs passed between the top level and the bitmap store.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package rwc_pkg;

    // Bitmap geometry. Word and bitmap sizes are powers of two so that the
    // word index and bit index are plain bit fields of the counter.
    localparam int WORD_BITS   = 64;
    localparam int BITMAP_BITS = 8192;
    localparam int NUM_WORDS   = BITMAP_BITS / WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int ADDR_W      = $clog2(NUM_WORDS);
    localparam int COUNT_W     = ADDR_W + 1;

    localparam int WINDOW_SIZE_DEF = 8128;

    localparam int CTR_W = 64;
    localparam logic [CTR_W-1:0] REJECT_LIMIT_RST = 64'hFFFF_FFFF_FFFF_DFFF;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EVAL,
        ST_RMW
    } state_t;

    typedef struct packed
    {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               clr_en;
        logic [ADDR_W-1:0]  clr_base;
        logic [COUNT_W-1:0] clr_count;
    } bm_rd_req_t;

    typedef struct packed
    {
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } bm_wr_req_t;

endpackage

`default_nettype wire

[hw/rtl/rwc_bitmap.sv]
// Circular bitmap store: a synchronous word memory plus one valid flag per word.
// A cleared or never written word reads as zero. Uses rwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwc_bitmap
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  rwc_pkg::bm_rd_req_t     rd_req,
    input  wire  rwc_pkg::bm_wr_req_t     wr_req,
    output logic [rwc_pkg::WORD_BITS-1:0] rd_data
);
    import rwc_pkg::*;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic                 rd_valid_next;
    logic [NUM_WORDS-1:0] valid_reg;
    logic [NUM_WORDS-1:0] valid_next;
    logic [NUM_WORDS-1:0] clr_mask;

    // Word j is cleared when its distance past the base is at least one and at most the count.
    // A count of NUM_WORDS clears every word.
    always_comb
    begin
        logic [ADDR_W-1:0] word_gap;
        for (int j = 0; j < NUM_WORDS; j++)
        begin
            word_gap    = ADDR_W'(j) - rd_req.clr_base - ADDR_W'(1);
            clr_mask[j] = rd_req.clr_en && ({1'b0, word_gap} < rd_req.clr_count);
        end
    end

    always_comb
    begin
        valid_next = valid_reg & ~clr_mask;
        rd_valid_next = valid_next[rd_req.rd_addr];
        if (wr_req.wr_en)
        begin
            valid_next[wr_req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_req.wr_en)
        begin
            mem[wr_req.wr_addr] <= wr_req.wr_data;
        end
        if (rd_req.rd_en)
        begin
            rd_data_reg <= mem[rd_req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_req.rd_en)
            begin
                rd_valid_reg <= rd_valid_next;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

[hw/rtl/replay_window_check_top.sv]
// Top level of the anti-replay sliding window check: window control FSM,
// highest-counter and limit registers, output register. Uses rwc_pkg, rwc_bitmap.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+----------------------
//  input    | in_valid / in_stall  | packet_counter [63:0]
//  output   | out_valid / out_stall| accepted
//  config   | cfg_wr_en            | cfg_wr_data [63:0]
//
// Each transaction runs in two states: EVAL checks the counter, clears the
// skipped words and reads its bitmap word; RMW sets the bit and writes it back.
// The bitmap memory port allows one read-modify-write per transaction.
// Reset clears the highest counter and all word valid flags at once; no clearing pass.
// The next input is taken while a result waits in the output register; a
// stalled output holds the write-back until the result can be loaded.
`timescale 1ns / 1ps
`default_nettype none

module replay_window_check_top
#(
    parameter int WINDOW_SIZE = rwc_pkg::WINDOW_SIZE_DEF
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire  [rwc_pkg::CTR_W-1:0]  packet_counter,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic                       accepted,
    input  wire                        cfg_wr_en,
    input  wire  [rwc_pkg::CTR_W-1:0]  cfg_wr_data
);
    import rwc_pkg::*;

    localparam int HI_W = CTR_W - BIT_W;

    state_t             state_reg, state_next;
    logic [CTR_W-1:0]   pc_reg, pc_next;
    logic [CTR_W-1:0]   highest_reg, highest_next;
    logic [CTR_W-1:0]   limit_reg;
    logic               rej_reg, rej_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic               out_valid_reg, out_valid_next;
    logic               accepted_reg, accepted_next;

    bm_rd_req_t           rd_req;
    bm_wr_req_t           wr_req;
    logic [WORD_BITS-1:0] rd_data;

    logic               in_accept;
    logic               out_free;
    logic [CTR_W-1:0]   t_val;
    logic               over_limit;
    logic               too_old;
    logic               reject;
    logic               forward;
    logic [HI_W-1:0]    word_diff;
    logic [COUNT_W-1:0] clr_count;
    logic [WORD_BITS-1:0] bit_onehot;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) || ((state_reg == ST_RMW) && out_free));
    assign in_accept = in_valid && !in_stall;

    // Window checks on the held counter; t_val is the counter plus one.
    assign t_val      = pc_reg + CTR_W'(1);
    assign over_limit = (highest_reg > limit_reg) || (pc_reg >= limit_reg);
    assign too_old    = (highest_reg > t_val)
                        && ((highest_reg - t_val) > CTR_W'(WINDOW_SIZE));
    assign reject     = over_limit || too_old;
    assign forward    = t_val > highest_reg;
    assign word_diff  = t_val[CTR_W-1:BIT_W] - highest_reg[CTR_W-1:BIT_W];
    assign clr_count  = (word_diff > HI_W'(NUM_WORDS)) ? COUNT_W'(NUM_WORDS)
                                                       : word_diff[COUNT_W-1:0];
    assign bit_onehot = WORD_BITS'(1) << bit_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        highest_next   = highest_reg;
        rej_next       = rej_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && out_stall;
        accepted_next  = accepted_reg;

        rd_req           = '0;
        rd_req.clr_base  = highest_reg[BIT_W +: ADDR_W];
        rd_req.clr_count = clr_count;
        wr_req           = '0;
        wr_req.wr_addr   = addr_reg;
        wr_req.wr_data   = rd_data | bit_onehot;

        if (in_accept)
        begin
            pc_next = packet_counter;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                rej_next       = reject;
                addr_next      = t_val[BIT_W +: ADDR_W];
                bit_next       = t_val[BIT_W-1:0];
                rd_req.rd_en   = !reject;
                rd_req.rd_addr = t_val[BIT_W +: ADDR_W];
                if (!reject && forward)
                begin
                    rd_req.clr_en = 1'b1;
                    highest_next  = t_val;
                end
                state_next = ST_RMW;
            end
            ST_RMW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    accepted_next  = !rej_reg && !(|(rd_data & bit_onehot));
                    wr_req.wr_en   = !rej_reg;
                    state_next     = in_accept ? ST_EVAL : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            highest_reg   <= '0;
            limit_reg     <= REJECT_LIMIT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg       <= pc_next;
        rej_reg      <= rej_next;
        addr_reg     <= addr_next;
        bit_reg      <= bit_next;
        accepted_reg <= accepted_next;
    end

    rwc_bitmap u_bitmap
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;

endmodule

`default_nettype wire
